[src/mpenv_pkg.sv]
// ---------------------------------------------------------------------------
// mpenv_pkg: shared types and constants of the breakpoint envelope generator
// Command codes, the stored point layout and the divider request bundle.
// ---------------------------------------------------------------------------
package mpenv_pkg;

	localparam int LEVEL_W  = 32;
	localparam int FRAMES_W = 16;
	localparam int SP_W     = 4;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_NOTE_ON = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_WRITE   = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic CFG_SUSTAIN = 1'b0;
	localparam logic CFG_LOOP    = 1'b1;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] lvl;
		logic [FRAMES_W-1:0]       frames;
	} point_t;

	// request to the serial divider: |diff| / den, sign applied afterward
	typedef struct packed {
		logic                neg;
		logic [LEVEL_W-1:0]  mag;
		logic [FRAMES_W-1:0] den;
	} div_req_t;

endpackage

[src/multi_point_envelope_generator.sv]
// ---------------------------------------------------------------------------
// multi_point_envelope_generator: breakpoint envelope, one value per tick
// Walks a table of (level, frames) points, stepping toward each target by
// (target - level) / frames remaining on a shared serial divider.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tuser: command; tdata: index, level, frames
// m_*       out  tvalid/tready      tdata: level, done_res, holding
// cfg_*     in   cfg_we (no wait)   cfg_addr: register index, cfg_wdata: value
//
// Write and release requests go straight to the output register; note-on and
// ticks that only reload a level first read the point memory; a moving tick
// also waits on the serial divider; a loop wrap adds a point 0 reload read.
// One request in flight: s_tready is high only while idle.
// The result sits in an output register; a stalled m_tready holds the
// sequencer in its final state until the register frees.
// Reset clears all control state and the point valid bits (unwritten points
// read as zero level, zero frames); no clearing pass is needed.
//
module multi_point_envelope_generator import mpenv_pkg::*; #(
	parameter int NUM_POINTS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	// request in
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [1:0]      s_tuser,    // [1:0] command
	input  logic [55:0]     s_tdata,    // [2:0] point_index, [34:3] point_level,
	                                    // [50:35] point_frames, [55:51] zero
	// result out
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [39:0]     m_tdata,    // [31:0] level, [32] done_res,
	                                    // [33] holding, [39:34] zero
	// configuration
	input  logic            cfg_we,
	input  logic            cfg_addr,
	input  logic [SP_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(NUM_POINTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,   // memory read issued
		S_USE  = 7'b0000100,   // read data available
		S_DIV  = 7'b0001000,   // waiting on divider
		S_ADV  = 7'b0010000,   // step count / segment end
		S_OUT  = 7'b0100000,   // load output register
		S_SPR  = 7'b1000000    // reserved spare code path, never entered
	} state_t;

	state_t state_q;

	// configuration
	logic signed [SP_W-1:0] sustain_q;
	logic                   loop_q;

	// point memory with per-entry valid bits
	point_t                 mem [NUM_POINTS];
	logic [NUM_POINTS-1:0]  valid_q;
	logic [IDX_W-1:0]       rd_addr_q;
	point_t                 rd_q;
	logic                   rd_vld_q;

	// envelope state
	logic signed [LEVEL_W-1:0] cur_q;
	logic [IDX_W-1:0]          ti_q;
	logic [FRAMES_W-1:0]       step_q;
	logic                      sustaining_q;
	logic                      finished_q;
	logic                      seg_q;      // read feeds segment math, else level reload
	logic [FRAMES_W-1:0]       n_q;

	// output register
	logic                      m_tvalid_q;
	logic [39:0]               m_tdata_q;

	// request decode
	cmd_t                      cmd;
	logic [2:0]                in_idx;
	logic signed [LEVEL_W-1:0] in_lvl;
	logic [FRAMES_W-1:0]       in_frames;
	logic                      accept;

	// datapath helpers
	logic signed [LEVEL_W-1:0] rd_lvl;
	logic [FRAMES_W-1:0]       rd_frames;
	logic signed [LEVEL_W:0]   diff;
	logic [FRAMES_W-1:0]       step_inc;
	logic                      sp_valid;
	logic                      sp_is_ti;
	logic                      sp_past_end;
	logic                      ti_last;

	div_req_t                  div_req;
	logic                      div_start;
	logic                      div_done;
	logic signed [LEVEL_W:0]   div_q;

	assign cmd       = cmd_t'(s_tuser);
	assign in_idx    = s_tdata[2:0];
	assign in_lvl    = s_tdata[34:3];
	assign in_frames = s_tdata[50:35];
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);

	assign rd_lvl    = rd_vld_q ? rd_q.lvl : '0;
	assign rd_frames = rd_vld_q ? rd_q.frames : '0;
	assign diff      = {rd_lvl[LEVEL_W-1], rd_lvl} - {cur_q[LEVEL_W-1], cur_q};
	assign step_inc  = step_q + 1'b1;

	assign sp_valid    = (int'(sustain_q) >= 0) && (int'(sustain_q) < NUM_POINTS);
	assign sp_is_ti    = (int'(sustain_q) == int'(ti_q));
	assign sp_past_end = (int'(sustain_q) + 1 >= NUM_POINTS);
	assign ti_last     = (int'(ti_q) + 1 >= NUM_POINTS);

	assign div_start   = (state_q == S_USE) && seg_q && (rd_frames > step_q);
	assign div_req.neg = diff[LEVEL_W];
	assign div_req.mag = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
	assign div_req.den = rd_frames - step_q;

	mpenv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_q)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sustain_q <= -SP_W'(1);
			loop_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_SUSTAIN: sustain_q <= cfg_wdata;
				CFG_LOOP:    loop_q    <= cfg_wdata[0];
				default:     ;
			endcase
		end
	end

	// point memory: write on a write request, registered read
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_WRITE && int'(in_idx) < NUM_POINTS) begin
			mem[IDX_W'(in_idx)] <= '{lvl: in_lvl, frames: in_frames};
		end
		rd_q     <= mem[rd_addr_q];
		rd_vld_q <= valid_q[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept && cmd == CMD_WRITE && int'(in_idx) < NUM_POINTS) begin
			valid_q[IDX_W'(in_idx)] <= 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			ti_q         <= IDX_W'(1);
			step_q       <= '0;
			sustaining_q <= 1'b0;
			finished_q   <= 1'b1;
			seg_q        <= 1'b0;
			rd_addr_q    <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			// S_OUT reloads the register itself on the same handshake
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_TICK: begin
								if (finished_q) begin
									rd_addr_q <= LAST_IDX;
									seg_q     <= 1'b0;
									state_q   <= S_RD;
								end else if (sustaining_q) begin
									step_q <= step_inc;
									seg_q  <= 1'b0;
									if (sp_valid) begin
										rd_addr_q <= IDX_W'(unsigned'(sustain_q));
										state_q   <= S_RD;
									end else begin
										state_q <= S_OUT;
									end
								end else begin
									rd_addr_q <= ti_q;
									seg_q     <= 1'b1;
									state_q   <= S_RD;
								end
							end
							CMD_NOTE_ON: begin
								sustaining_q <= 1'b0;
								finished_q   <= 1'b0;
								ti_q         <= IDX_W'(1);
								step_q       <= '0;
								rd_addr_q    <= '0;
								seg_q        <= 1'b0;
								state_q      <= S_RD;
							end
							CMD_RELEASE: begin
								seg_q   <= 1'b0;
								state_q <= S_OUT;
								if (!sustain_q[SP_W-1]) begin
									sustaining_q <= 1'b0;
									step_q       <= '0;
									if (sp_past_end) begin
										finished_q <= 1'b1;
										ti_q       <= LAST_IDX;
									end else begin
										ti_q <= IDX_W'(unsigned'(sustain_q) + 1'b1);
									end
								end
							end
							CMD_WRITE: begin
								seg_q   <= 1'b0;
								state_q <= S_OUT;
							end
							default: begin
								seg_q   <= 1'b0;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_RD: state_q <= S_USE;
				S_USE: begin
					if (seg_q) begin
						n_q     <= rd_frames;
						state_q <= div_start ? S_DIV : S_ADV;
					end else begin
						cur_q   <= rd_lvl;
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						cur_q   <= cur_q + div_q[LEVEL_W-1:0];
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (step_inc >= n_q) begin
						step_q <= '0;
						if (sp_is_ti) begin
							sustaining_q <= 1'b1;
							state_q      <= S_OUT;
						end else if (ti_last) begin
							if (loop_q) begin
								// wrap: reload point 0 level, aim at point 1
								ti_q      <= IDX_W'(1);
								rd_addr_q <= '0;
								seg_q     <= 1'b0;
								state_q   <= S_RD;
							end else begin
								finished_q <= 1'b1;
								ti_q       <= LAST_IDX;
								state_q    <= S_OUT;
							end
						end else begin
							ti_q    <= ti_q + 1'b1;
							state_q <= S_OUT;
						end
					end else begin
						step_q  <= step_inc;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_SPR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {6'b0, sustaining_q, finished_q, cur_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[src/mpenv_div.sv]
// ---------------------------------------------------------------------------
// mpenv_div: serial signed step divider
// Restoring division, one quotient bit per cycle, truncation toward zero.
// ---------------------------------------------------------------------------
module mpenv_div import mpenv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  div_req_t                req,
	output logic                    done,
	output logic signed [LEVEL_W:0] quot
);

	localparam int CNT_W = $clog2(LEVEL_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;
	logic [FRAMES_W-1:0] den_q;
	logic [FRAMES_W-1:0] rem_q;
	logic [LEVEL_W-1:0]  quo_q;

	logic [FRAMES_W:0]   shifted;
	logic                fits;

	assign shifted = {rem_q, quo_q[LEVEL_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(LEVEL_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= req.neg;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.mag;
		end else if (busy_q) begin
			rem_q <= fits ? FRAMES_W'(shifted - {1'b0, den_q}) : shifted[FRAMES_W-1:0];
			quo_q <= {quo_q[LEVEL_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

[dv/envelope_monitor.sv]
// ---------------------------------------------------------------------------
// envelope_monitor: request/result scoreboard for the envelope generator
// Mirrors the point table and segment walk for every accepted request and
// compares each accepted result against the oldest predicted one.
// ---------------------------------------------------------------------------
module envelope_monitor import mpenv_pkg::*; #(
	parameter int NUM_POINTS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tready,
	input  logic [1:0]      s_tuser,    // [1:0] command
	input  logic [55:0]     s_tdata,    // [2:0] index, [34:3] level, [50:35] frames
	input  logic            m_tvalid,
	input  logic            m_tready,
	input  logic [39:0]     m_tdata,    // [31:0] level, [32] done_res, [33] holding
	input  logic            cfg_we,
	input  logic            cfg_addr,
	input  logic [SP_W-1:0] cfg_wdata,
	output int              mismatches,
	output int              outstanding
);

	// laid out to match m_tdata[33:0]
	typedef struct packed {
		logic                      holding;
		logic                      done_res;
		logic signed [LEVEL_W-1:0] level;
	} env_result_t;

	logic signed [LEVEL_W-1:0] level_mem [NUM_POINTS];
	logic [FRAMES_W-1:0]       frames_mem [NUM_POINTS];
	logic signed [LEVEL_W-1:0] cur_level;
	int                        tgt;
	logic [FRAMES_W-1:0]       steps;
	logic                      sustaining;
	logic                      finished;
	logic signed [SP_W-1:0]    sustain_pt;
	logic                      loop_on;

	env_result_t expected_levels [$];

	task automatic clear_envelope();
		for (int i = 0; i < NUM_POINTS; i++) begin
			level_mem[i]  = '0;
			frames_mem[i] = '0;
		end
		cur_level  = '0;
		tgt        = 1;
		steps      = '0;
		sustaining = 1'b0;
		finished   = 1'b1;
		sustain_pt = -4'sd1;
		loop_on    = 1'b0;
	endtask

	// one frame tick: hold the last or sustain level or move toward the target, then handle the segment end
	task automatic tick_envelope();
		int     sp;
		longint gap;
		longint span;
		sp = sustain_pt;
		if (finished) begin
			cur_level = level_mem[NUM_POINTS-1];
			return;
		end
		if (sustaining) begin
			// an out-of-range sustain index keeps the level where it is
			if (sp >= 0 && sp < NUM_POINTS)
				cur_level = level_mem[sp];
		end else if (frames_mem[tgt] > steps) begin
			gap       = longint'(level_mem[tgt]) - longint'(cur_level);
			span      = frames_mem[tgt] - steps;
			cur_level = 32'(longint'(cur_level) + gap / span);
		end
		steps = steps + 1'b1;
		if (!sustaining && steps >= frames_mem[tgt]) begin
			if (tgt == sp)
				sustaining = 1'b1;
			else
				tgt++;
			if (tgt >= NUM_POINTS) begin
				if (loop_on) begin
					cur_level = level_mem[0];
					tgt       = 1;
				end else begin
					finished = 1'b1;
					tgt      = NUM_POINTS - 1;
				end
			end
			steps = '0;
		end
	endtask

	task automatic release_envelope();
		int sp;
		sp = sustain_pt;
		if (sp < 0)
			return;
		sustaining = 1'b0;
		steps      = '0;
		if (sp + 1 >= NUM_POINTS) begin
			finished = 1'b1;
			tgt      = NUM_POINTS - 1;
		end else begin
			tgt = sp + 1;
		end
	endtask

	task automatic predict_envelope(input cmd_t cmd, input logic [2:0] idx,
			input logic signed [LEVEL_W-1:0] lvl, input logic [FRAMES_W-1:0] frm,
			output env_result_t res);
		case (cmd)
			CMD_TICK: begin
				tick_envelope();
			end
			CMD_NOTE_ON: begin
				sustaining = 1'b0;
				finished   = 1'b0;
				cur_level  = level_mem[0];
				tgt        = 1;
				steps      = '0;
			end
			CMD_RELEASE: begin
				release_envelope();
			end
			default: begin
				if (idx < NUM_POINTS) begin
					level_mem[idx]  = lvl;
					frames_mem[idx] = frm;
				end
			end
		endcase
		res.level    = cur_level;
		res.done_res = finished;
		res.holding  = sustaining;
	endtask

	always @(posedge clk or negedge arst_n) begin
		env_result_t want;
		env_result_t got;
		int          bad;
		if (!arst_n) begin
			clear_envelope();
			expected_levels.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				if (cfg_addr == CFG_SUSTAIN)
					sustain_pt = cfg_wdata;
				else
					loop_on = cfg_wdata[0];
			end
			if (s_tvalid && s_tready) begin
				predict_envelope(cmd_t'(s_tuser), s_tdata[2:0], s_tdata[34:3],
					s_tdata[50:35], want);
				expected_levels.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[33:0];
				if (expected_levels.size() == 0) begin
					$error("unexpected result: level %h done_res %b holding %b",
						got.level, got.done_res, got.holding);
					bad++;
				end else begin
					want = expected_levels.pop_front();
					if (got.level !== want.level) begin
						$error("level: expected %h, actual %h", want.level, got.level);
						bad++;
					end
					if (got.done_res !== want.done_res) begin
						$error("done_res: expected %b, actual %b", want.done_res,
							got.done_res);
						bad++;
					end
					if (got.holding !== want.holding) begin
						$error("holding: expected %b, actual %b", want.holding,
							got.holding);
						bad++;
					end
				end
			end
			mismatches  <= mismatches + bad;
			outstanding <= expected_levels.size();
		end
	end

endmodule

[dv/multi_point_envelope_generator_test.sv]
// ---------------------------------------------------------------------------
// multi_point_envelope_generator_test: stimulus and verdict for the envelope
// A directed pass over the corner cases, then phases of random point loads,
// note-ons, ticks and releases under several sustain/loop settings, with
// random stalls on both streams. Checking lives in envelope_monitor.
// ---------------------------------------------------------------------------
module multi_point_envelope_generator_test;
	import mpenv_pkg::*;

	localparam int NUM_POINTS      = 8;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int SETTLE_CYCLES   = 60;     // idle margin at the end of each drain
	localparam int HOLD_OFF_CYCLES = 400;    // long result back-pressure stretch
	localparam int PHASES          = 15;
	localparam int PHASE_ITEMS     = 100;
	localparam int CALM_PHASES     = 3;      // last phases run without idling

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            s_tvalid  = 1'b0;
	logic            s_tready;
	logic [1:0]      s_tuser   = CMD_TICK;
	logic [55:0]     s_tdata   = '0;
	logic            m_tvalid;
	logic            m_tready  = 1'b0;
	logic [39:0]     m_tdata;
	logic            cfg_we    = 1'b0;
	logic            cfg_addr  = CFG_SUSTAIN;
	logic [SP_W-1:0] cfg_wdata = '0;

	int          mismatches;
	int          outstanding;
	bit          calm         = 1'b0;   // no idling on either side
	bit          hold_request = 1'b0;   // asks the receiver for a long hold-off
	int unsigned cycles       = 0;

	multi_point_envelope_generator #(
		.NUM_POINTS(NUM_POINTS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	envelope_monitor #(
		.NUM_POINTS(NUM_POINTS)
	) monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// result side: mostly ready, random stall bursts, one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one request and hold it until accepted. Valid stays high into the
	// next request unless a gap is drawn, so it never drops and rises in one step.
	task automatic send_request(input cmd_t cmd, input logic [2:0] idx,
			input logic [31:0] lvl, input logic [15:0] frm);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'b0, frm, lvl, idx};
		do @(posedge clk); while (!s_tready);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// sender pause: wait out every pending result, then let the block go idle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);   // outstanding is registered by the monitor
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [SP_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// levels: full range, rails, and small Q16.16 values near zero
	function automatic logic [31:0] pick_level();
		int v;
		case ($urandom_range(0, 5))
			0: pick_level = 32'h7FFF_FFFF;
			1: pick_level = 32'h8000_0000;
			2: begin
				v = $urandom_range(0, 2000);
				pick_level = (v - 1000) <<< 16;
			end
			default: pick_level = $urandom;
		endcase
	endfunction

	// frame counts: mostly short segments so the walk reaches its end states
	function automatic logic [15:0] pick_frames();
		case ($urandom_range(0, 15))
			0: pick_frames = 16'hFFFF;
			1: pick_frames = 16'($urandom);
			2, 3: pick_frames = '0;
			default: pick_frames = 16'($urandom_range(1, 8));
		endcase
	endfunction

	// one random request: ticks dominate, with point loads, restarts, releases
	// and a share of fully random noise
	task automatic random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			send_request(CMD_TICK, 3'($urandom), 32'($urandom), 16'($urandom));
		else if (r < 70)
			send_request(CMD_WRITE, 3'($urandom), pick_level(), pick_frames());
		else if (r < 80)
			send_request(CMD_NOTE_ON, 3'($urandom), 32'($urandom), 16'($urandom));
		else if (r < 90)
			send_request(CMD_RELEASE, 3'($urandom), 32'($urandom), 16'($urandom));
		else
			send_request(cmd_t'($urandom_range(0, 3)), 3'($urandom), 32'($urandom),
				16'($urandom));
	endtask

	initial begin
		int              sp;
		int              lp;
		int              left;
		logic [SP_W-1:0] sp_bits;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// tick and release straight out of reset: finished, no sustain point
		send_request(CMD_TICK, 3'd0, '0, '0);
		send_request(CMD_RELEASE, 3'd0, '0, '0);
		// rail-to-rail first segment, zero-length second, short tail
		send_request(CMD_WRITE, 3'd0, 32'h8000_0000, 16'd0);
		send_request(CMD_WRITE, 3'd1, 32'h7FFF_FFFF, 16'd3);
		send_request(CMD_WRITE, 3'd2, 32'h0001_0000, 16'd0);
		send_request(CMD_WRITE, 3'd3, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(CMD_WRITE, 3'd7, 32'h1234_5678, 16'd1);
		send_request(CMD_NOTE_ON, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
		repeat (6) send_request(CMD_TICK, 3'd0, '0, '0);
		drain();

		// sustain at point 2: reach the hold, keep counting while held
		write_reg(CFG_SUSTAIN, 4'd2);
		send_request(CMD_NOTE_ON, 3'd0, '0, '0);
		repeat (5) send_request(CMD_TICK, 3'd0, '0, '0);
		drain();
		// sustain index pulled away while holding: level stays, release ignored
		write_reg(CFG_SUSTAIN, 4'hF);
		send_request(CMD_TICK, 3'd0, '0, '0);
		send_request(CMD_RELEASE, 3'd0, '0, '0);
		drain();
		// release from the last point as sustain: finishes, tick shows last level
		write_reg(CFG_SUSTAIN, 4'd7);
		send_request(CMD_RELEASE, 3'd0, '0, '0);
		send_request(CMD_TICK, 3'd0, '0, '0);
		drain();

		// --- random phases ---
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin sp = -1; lp = 0; end
				1: begin sp = 7;  lp = 0; end
				2: begin sp = 3;  lp = 1; end
				3: begin sp = 0;  lp = 1; end
				4: begin sp = -8; lp = 0; end
				5: begin sp = 7;  lp = 1; end
				default: begin
					if ($urandom_range(0, 3) == 0)
						sp = $urandom_range(0, 15) - 8;
					else
						sp = $urandom_range(0, 8) - 1;
					lp = $urandom_range(0, 1);
				end
			endcase
			if (phase >= PHASES - CALM_PHASES)
				calm = 1'b1;
			sp_bits = 4'(sp);
			write_reg(CFG_SUSTAIN, sp_bits);
			// loop register only looks at bit 0; upper bits go random
			write_reg(CFG_LOOP, {3'($urandom), 1'(lp)});

			// one phase with the result side blocked while requests keep coming
			if (phase == 4)
				hold_request = 1'b1;

			left = PHASE_ITEMS;
			// usually a fresh envelope; otherwise carry the old walk into the new setting
			if ($urandom_range(0, 2) != 0) begin
				for (int i = 0; i < NUM_POINTS; i++)
					send_request(CMD_WRITE, 3'(i), pick_level(), pick_frames());
				send_request(CMD_NOTE_ON, 3'($urandom), 32'($urandom), 16'($urandom));
				left -= NUM_POINTS + 1;
			end
			repeat (left) random_request();
			drain();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
